### rtl/cvs_pkg.sv
// Shared types and codes for the cosine top-k vector search core.
// No dependencies; imported by the front end, the engine and the top level.
package cvs_pkg;

  // Command codes carried by each item
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_DIM      = 2'd1,
    STS_FULL     = 2'd2,
    STS_NO_MATCH = 2'd3
  } status_t;

  // Configuration register indexes
  localparam logic REG_MATCH_LIMIT = 1'b0;
  localparam logic REG_MIN_SCORE   = 1'b1;

  localparam logic [4:0] MATCH_LIMIT_RST = 5'd16;
  localparam logic signed [15:0] MIN_SCORE_RST = 16'sh8000;

  // Input item
  typedef struct packed {
    cmd_t               cmd;
    logic signed [15:0] element_value;
    logic               element_last;
    logic [15:0]        doc_id;
  } item_t;

  // Result item
  typedef struct packed {
    status_t            status;
    logic [15:0]        match_id;
    logic signed [15:0] match_score;
    logic [8:0]         entry_count;
    logic               result_last;
  } result_t;

  // Job handed from the front end to the engine (length travels beside it)
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] doc_id;
    logic        overflow;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  // Engine sequencer states
  typedef enum logic [4:0] {
    BS_IDLE,
    BS_CHECK,
    BS_A_KRD,
    BS_A_KCMP,
    BS_A_CHK,
    BS_SUM,
    BS_SQRT,
    BS_N_RD,
    BS_N_LD,
    BS_N_DIV,
    BS_N_WR,
    BS_A_COMMIT,
    BS_Q_DOT,
    BS_Q_WR,
    BS_S_START,
    BS_S_SWEEP,
    BS_S_MARK,
    BS_S_KEY,
    BS_S_DONE,
    BS_R_KRD,
    BS_R_KCMP,
    BS_R_COPY,
    BS_R_KWR,
    BS_R_DONE
  } bstate_t;

  // Pack one result item
  function automatic result_t make_res(status_t st, logic [15:0] id,
                                       logic signed [15:0] score,
                                       logic [8:0] cnt, logic last);
    result_t r;
    r.status      = st;
    r.match_id    = id;
    r.match_score = score;
    r.entry_count = cnt;
    r.result_last = last;
    return r;
  endfunction

endpackage

### rtl/cvs_fifo.sv
// Two-entry job queue between the front end and the engine.
// Depends on nothing but its width parameter.
module cvs_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;

  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);
  assign rdata = slots[rptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) begin
        slots[wptr] <= wdata;
        wptr        <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
    end
  end

endmodule

### rtl/cvs_front.sv
// Front end: accepts items, loads vector components into staging, and
// queues a job for each final component, remove or clear. Uses cvs_pkg.
module cvs_front import cvs_pkg::*; #(
  parameter int MAX_DIM = 64,
  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int LEN_W  = $clog2(MAX_DIM + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  item_t               item,
  output logic                push,
  output job_t                job,
  output logic [LEN_W-1:0]    job_len,
  input  logic [DIM_W-1:0]    stg_raddr,
  output logic signed [15:0]  stg_rdata
);

  logic signed [15:0] stg_mem [MAX_DIM];
  logic [LEN_W-1:0]   stg_len;
  logic               ovf;
  logic               is_elem;
  logic               room;
  logic [LEN_W-1:0]   len_new;
  logic               ovf_new;

  // Classify the item
  always_comb begin
    is_elem = (item.cmd == CMD_ADD) || (item.cmd == CMD_QUERY);
    room    = !ovf && (stg_len < LEN_W'(MAX_DIM));
    len_new = room ? stg_len + 1'b1 : stg_len;
    ovf_new = !room;
    push    = accept && (!is_elem || item.element_last);
    job.cmd      = item.cmd;
    job.doc_id   = item.doc_id;
    job.overflow = is_elem ? ovf_new : 1'b0;
    job_len      = len_new;
  end

  // Staging length and overflow mark
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_len <= '0;
      ovf     <= 1'b0;
    end else if (accept) begin
      if (is_elem && !item.element_last) begin
        stg_len <= len_new;
        ovf     <= ovf_new;
      end else if (is_elem || item.cmd == CMD_CLEAR) begin
        stg_len <= '0;
        ovf     <= 1'b0;
      end
    end
  end

  // Staging memory
  always_ff @(posedge clk) begin
    if (accept && is_elem && room) begin
      stg_mem[stg_len[DIM_W-1:0]] <= item.element_value;
    end
    stg_rdata <= stg_mem[stg_raddr];
  end

endmodule

### rtl/cvs_back.sv
// Engine: carries out queued jobs (normalize and store, query and rank,
// remove with compaction, clear) over the vector, key and score memories.
// Uses cvs_pkg; reads staging through the front end's read port.
module cvs_back import cvs_pkg::*; #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_DIM     = 64,
  parameter int MAX_MATCHES = 16,
  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int LEN_W  = $clog2(MAX_DIM + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fifo_empty,
  input  job_t               fifo_job,
  input  logic [LEN_W-1:0]   fifo_len,
  output logic               pop,
  output logic [DIM_W-1:0]   stg_raddr,
  input  logic signed [15:0] stg_rdata,
  input  logic [4:0]         match_limit,
  input  logic signed [15:0] min_score,
  output logic               busy,
  output logic               done,
  output result_t            result
);

  localparam int SLOT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int IW      = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int MT_W    = $clog2(MAX_MATCHES + 1);
  localparam int VADDR_W = SLOT_W + DIM_W;
  localparam int VDEPTH  = MAX_ENTRIES * (2 ** DIM_W);
  localparam int ACC_W   = 32 + DIM_W;
  localparam int N_W     = ACC_W + 16;
  localparam int RAD_W   = N_W + (N_W % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int QB      = 17;
  localparam int DN_W    = 40;
  localparam int STEP_W  = $clog2(ROOT_W + 1);

  bstate_t state, state_next;

  // Memories
  logic [15:0] vmem [VDEPTH];
  logic [15:0] kmem [MAX_ENTRIES];
  logic [16:0] smem [MAX_ENTRIES];
  logic [15:0] qmem [MAX_DIM];
  logic [15:0] vmem_rd, kmem_rd, qmem_rd;
  logic [16:0] smem_rd;
  logic               vmem_we, kmem_we, smem_we, qmem_we;
  logic [VADDR_W-1:0] vmem_waddr, vmem_raddr;
  logic [15:0]        vmem_wdata, kmem_wdata;
  logic [SLOT_W-1:0]  kmem_waddr, kmem_raddr, smem_waddr, smem_raddr;
  logic [16:0]        smem_wdata;

  // Job and store state
  job_t             job;
  logic [LEN_W-1:0] job_len;
  logic [CNT_W-1:0] count;
  logic             dim_known;
  logic [LEN_W-1:0] dim;

  // Sweep counters and pipeline
  logic [IW-1:0]     iss;
  logic [CNT_W-1:0]  slot;
  logic [CNT_W-1:0]  wptr;
  logic              found;
  logic              rd_v, mul_v;
  logic [SLOT_W-1:0] rd_idx;
  logic [DIM_W-1:0]  rd_j;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [15:0]      op_a, op_b;

  // Square root and divider
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W:0]   srem;
  logic [STEP_W-1:0] step;
  logic              zero;
  logic              neg;
  logic [ROOT_W:0]   drem;
  logic [QB-1:0]     dlow;
  logic [QB-1:0]     quo;

  // Ranking
  logic [SLOT_W-1:0]  best;
  logic signed [15:0] best_score;
  logic               have;
  logic [MT_W-1:0]    n;
  logic [MT_W-1:0]    lim;
  logic               pend_v;
  logic [15:0]        pend_id;
  logic signed [15:0] pend_score;
  logic [15:0]        key_hold;

  // Derived conditions
  logic [IW-1:0]      iss_lim;
  logic               issuing;
  logic               pipe_done;
  logic               mac_phase;
  logic               dim_err;
  logic               a_full;
  logic               last_comp;
  logic [IW-1:0]      iss_nx;
  logic [ROOT_W+2:0]  sq_rt, sq_trial;
  logic               sq_ge;
  logic [ROOT_W:0]    dv_trial;
  logic               dv_ge;
  logic [16:0]        mag;
  logic [DN_W-1:0]    dnum;
  logic signed [15:0] unit;
  logic [ACC_W-1:0]   acc_u, acc_mag, acc_rnd;
  logic [ACC_W-16:0]  sc_r;
  logic signed [15:0] score;
  logic signed [15:0] rd_score;
  logic               cand;

  // Shared conditions, arithmetic steps and rounding
  always_comb begin
    case (state)
      BS_SUM, BS_Q_DOT: iss_lim = IW'(job_len);
      BS_S_SWEEP:       iss_lim = IW'(count);
      BS_R_COPY:        iss_lim = IW'(MAX_DIM);
      default:          iss_lim = '0;
    endcase
    issuing   = (iss < iss_lim) && !(state == BS_Q_DOT && slot == count);
    mac_phase = (state == BS_SUM) || (state == BS_Q_DOT);
    pipe_done = !issuing && !rd_v && !mul_v;
    dim_err   = job.overflow || (dim_known && job_len != dim);
    a_full    = !found && (count >= CNT_W'(MAX_ENTRIES));
    iss_nx    = iss + 1'b1;
    last_comp = (iss_nx == IW'(job_len));
    lim = (32'(match_limit) > MAX_MATCHES) ? MT_W'(MAX_MATCHES) : MT_W'(match_limit);

    op_a = (state == BS_SUM) ? stg_rdata : $signed(qmem_rd);
    op_b = (state == BS_SUM) ? stg_rdata : $signed(vmem_rd);

    // one root bit per step
    sq_rt    = {srem, rad[RAD_W-1 -: 2]};
    sq_trial = {1'b0, root, 2'b01};
    sq_ge    = (sq_rt >= sq_trial);

    // one quotient bit per step
    dv_trial = {drem[ROOT_W-1:0], dlow[QB-1]};
    dv_ge    = (dv_trial >= {1'b0, root});

    mag  = stg_rdata[15] ? 17'(-$signed({stg_rdata[15], stg_rdata})) : {1'b0, stg_rdata};
    dnum = (DN_W'(mag) << 23) + DN_W'(root >> 1);

    // saturated unit component
    if (zero) begin
      unit = '0;
    end else if (neg) begin
      unit = (quo > QB'(32768)) ? 16'sh8000 : $signed(16'(-quo));
    end else begin
      unit = (quo > QB'(32767)) ? 16'sh7fff : $signed(quo[15:0]);
    end

    // dot product rounded half away from zero, saturated
    acc_u   = acc;
    acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : acc_u;
    acc_rnd = acc_mag + ACC_W'(16384);
    sc_r    = acc_rnd[ACC_W-1:15];
    if (acc[ACC_W-1]) begin
      score = (sc_r > (ACC_W-15)'(32768)) ? 16'sh8000 : $signed(16'(-sc_r));
    end else begin
      score = (sc_r > (ACC_W-15)'(32767)) ? 16'sh7fff : $signed(sc_r[15:0]);
    end

    rd_score = $signed(smem_rd[15:0]);
    cand     = !smem_rd[16] && (!have || rd_score > best_score);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE:     if (!fifo_empty) state_next = BS_CHECK;
      BS_CHECK: begin
        case (job.cmd)
          CMD_CLEAR:  state_next = BS_IDLE;
          CMD_REMOVE: state_next = BS_R_KRD;
          CMD_ADD:    state_next = dim_err ? BS_IDLE : BS_A_KRD;
          default:    state_next = dim_err ? BS_IDLE : BS_SUM;
        endcase
      end
      BS_A_KRD: begin
        if (job.doc_id == 16'd0 || iss == IW'(count)) state_next = BS_A_CHK;
        else state_next = BS_A_KCMP;
      end
      BS_A_KCMP:   state_next = (kmem_rd == job.doc_id) ? BS_A_CHK : BS_A_KRD;
      BS_A_CHK:    state_next = a_full ? BS_IDLE : BS_SUM;
      BS_SUM:      if (pipe_done) state_next = (acc == '0) ? BS_N_RD : BS_SQRT;
      BS_SQRT:     if (step == STEP_W'(ROOT_W - 1)) state_next = BS_N_RD;
      BS_N_RD:     state_next = BS_N_LD;
      BS_N_LD:     state_next = zero ? BS_N_WR : BS_N_DIV;
      BS_N_DIV:    if (step == STEP_W'(QB - 1)) state_next = BS_N_WR;
      BS_N_WR: begin
        if (!last_comp) state_next = BS_N_RD;
        else if (job.cmd == CMD_ADD) state_next = BS_A_COMMIT;
        else state_next = BS_Q_DOT;
      end
      BS_A_COMMIT: state_next = BS_IDLE;
      BS_Q_DOT: begin
        if (slot == count) state_next = BS_S_START;
        else if (pipe_done) state_next = BS_Q_WR;
      end
      BS_Q_WR:     state_next = BS_Q_DOT;
      BS_S_START:  state_next = (n >= lim) ? BS_S_DONE : BS_S_SWEEP;
      BS_S_SWEEP:  if (pipe_done) state_next = BS_S_MARK;
      BS_S_MARK:   state_next = have ? BS_S_KEY : BS_S_DONE;
      BS_S_KEY:    state_next = BS_S_START;
      BS_S_DONE:   state_next = BS_IDLE;
      BS_R_KRD:    state_next = (slot == count) ? BS_R_DONE : BS_R_KCMP;
      BS_R_KCMP: begin
        if (kmem_rd == job.doc_id || wptr == slot) state_next = BS_R_KRD;
        else state_next = BS_R_COPY;
      end
      BS_R_COPY:   if (pipe_done) state_next = BS_R_KWR;
      BS_R_KWR:    state_next = BS_R_KRD;
      BS_R_DONE:   state_next = BS_IDLE;
      default:     state_next = BS_IDLE;
    endcase
  end

  // Memory controls and handshake outputs
  always_comb begin
    pop  = (state == BS_IDLE) && !fifo_empty;
    busy = (state != BS_IDLE);
    stg_raddr = iss[DIM_W-1:0];

    vmem_raddr = {slot[SLOT_W-1:0], iss[DIM_W-1:0]};
    vmem_we    = (state == BS_N_WR && job.cmd == CMD_ADD) || (state == BS_R_COPY && rd_v);
    if (state == BS_N_WR) begin
      vmem_waddr = {slot[SLOT_W-1:0], iss[DIM_W-1:0]};
      vmem_wdata = unit;
    end else begin
      vmem_waddr = {wptr[SLOT_W-1:0], rd_j};
      vmem_wdata = vmem_rd;
    end

    qmem_we = (state == BS_N_WR) && (job.cmd == CMD_QUERY);

    kmem_we = (state == BS_A_COMMIT) || (state == BS_R_KWR);
    if (state == BS_A_COMMIT) begin
      kmem_waddr = slot[SLOT_W-1:0];
      kmem_wdata = job.doc_id;
    end else begin
      kmem_waddr = wptr[SLOT_W-1:0];
      kmem_wdata = key_hold;
    end
    if (state == BS_S_MARK) kmem_raddr = best;
    else if (state == BS_A_KRD) kmem_raddr = iss[SLOT_W-1:0];
    else kmem_raddr = slot[SLOT_W-1:0];

    smem_raddr = iss[SLOT_W-1:0];
    smem_we    = (state == BS_Q_WR) || (state == BS_S_MARK && have);
    if (state == BS_Q_WR) begin
      smem_waddr = slot[SLOT_W-1:0];
      smem_wdata = {(score < min_score), score};
    end else begin
      smem_waddr = best;
      smem_wdata = {1'b1, best_score};
    end
  end

  // Memory arrays with registered reads
  always_ff @(posedge clk) begin
    if (vmem_we) vmem[vmem_waddr] <= vmem_wdata;
    vmem_rd <= vmem[vmem_raddr];
  end

  always_ff @(posedge clk) begin
    if (kmem_we) kmem[kmem_waddr] <= kmem_wdata;
    kmem_rd <= kmem[kmem_raddr];
  end

  always_ff @(posedge clk) begin
    if (smem_we) smem[smem_waddr] <= smem_wdata;
    smem_rd <= smem[smem_raddr];
  end

  always_ff @(posedge clk) begin
    if (qmem_we) qmem[iss[DIM_W-1:0]] <= unit;
    qmem_rd <= qmem[iss[DIM_W-1:0]];
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      count     <= '0;
      dim_known <= 1'b0;
      dim       <= '0;
      done      <= 1'b0;
      rd_v      <= 1'b0;
      mul_v     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;

      // shared read / multiply / accumulate pipeline
      rd_v   <= issuing;
      mul_v  <= rd_v && mac_phase;
      rd_idx <= iss[SLOT_W-1:0];
      rd_j   <= iss[DIM_W-1:0];
      if (issuing) iss <= iss_nx;
      if (rd_v) prod <= op_a * op_b;
      if (mul_v) acc <= acc + ACC_W'(prod);

      case (state)
        BS_IDLE: begin
          if (!fifo_empty) begin
            job     <= fifo_job;
            job_len <= fifo_len;
          end
        end
        BS_CHECK: begin
          iss   <= '0;
          acc   <= '0;
          found <= 1'b0;
          slot  <= (job.cmd == CMD_REMOVE) ? '0 : count;
          wptr  <= '0;
          if (job.cmd == CMD_CLEAR) begin
            count     <= '0;
            dim_known <= 1'b0;
            dim       <= '0;
            done      <= 1'b1;
            result    <= make_res(STS_OK, 16'd0, 16'sd0, 9'd0, 1'b1);
          end else if (job.cmd != CMD_REMOVE && dim_err) begin
            done   <= 1'b1;
            result <= make_res(STS_DIM, 16'd0, 16'sd0, 9'(count), 1'b1);
          end
        end
        BS_A_KCMP: begin
          if (kmem_rd == job.doc_id) begin
            found <= 1'b1;
            slot  <= CNT_W'(iss);
          end else begin
            iss <= iss_nx;
          end
        end
        BS_A_CHK: begin
          iss <= '0;
          acc <= '0;
          if (a_full) begin
            done   <= 1'b1;
            result <= make_res(STS_FULL, 16'd0, 16'sd0, 9'(count), 1'b1);
          end
        end
        BS_SUM: begin
          if (pipe_done) begin
            zero <= (acc == '0);
            rad  <= RAD_W'({acc_u, 16'h0000});
            root <= '0;
            srem <= '0;
            step <= '0;
            iss  <= '0;
          end
        end
        BS_SQRT: begin
          srem <= sq_ge ? (ROOT_W+1)'(sq_rt - sq_trial) : (ROOT_W+1)'(sq_rt);
          root <= {root[ROOT_W-2:0], sq_ge};
          rad  <= rad << 2;
          step <= step + 1'b1;
        end
        BS_N_LD: begin
          neg  <= stg_rdata[15];
          drem <= (ROOT_W+1)'(dnum >> QB);
          dlow <= dnum[QB-1:0];
          quo  <= '0;
          step <= '0;
        end
        BS_N_DIV: begin
          drem <= dv_ge ? dv_trial - {1'b0, root} : dv_trial;
          quo  <= {quo[QB-2:0], dv_ge};
          dlow <= dlow << 1;
          step <= step + 1'b1;
        end
        BS_N_WR: begin
          iss <= iss_nx;
          if (last_comp && job.cmd == CMD_QUERY) begin
            slot <= '0;
            iss  <= '0;
            acc  <= '0;
          end
        end
        BS_A_COMMIT: begin
          if (!found) count <= count + 1'b1;
          dim_known <= 1'b1;
          dim       <= job_len;
          done      <= 1'b1;
          result    <= make_res(STS_OK, 16'd0, 16'sd0,
                                9'(found ? count : count + 1'b1), 1'b1);
        end
        BS_Q_DOT: begin
          if (slot == count) begin
            n      <= '0;
            pend_v <= 1'b0;
          end
        end
        BS_Q_WR: begin
          slot <= slot + 1'b1;
          iss  <= '0;
          acc  <= '0;
        end
        BS_S_START: begin
          iss  <= '0;
          have <= 1'b0;
        end
        BS_S_SWEEP: begin
          if (rd_v && cand) begin
            best       <= rd_idx;
            best_score <= rd_score;
            have       <= 1'b1;
          end
        end
        BS_S_KEY: begin
          if (pend_v) begin
            done   <= 1'b1;
            result <= make_res(STS_OK, pend_id, pend_score, 9'(count), 1'b0);
          end
          pend_id    <= kmem_rd;
          pend_score <= best_score;
          pend_v     <= 1'b1;
          n          <= n + 1'b1;
        end
        BS_S_DONE: begin
          done <= 1'b1;
          if (pend_v) begin
            result <= make_res(STS_OK, pend_id, pend_score, 9'(count), 1'b1);
          end else begin
            result <= make_res(STS_NO_MATCH, 16'd0, 16'sd0, 9'(count), 1'b1);
          end
        end
        BS_R_KCMP: begin
          if (kmem_rd == job.doc_id) begin
            slot <= slot + 1'b1;
          end else if (wptr == slot) begin
            wptr <= wptr + 1'b1;
            slot <= slot + 1'b1;
          end else begin
            key_hold <= kmem_rd;
            iss      <= '0;
          end
        end
        BS_R_KWR: begin
          wptr <= wptr + 1'b1;
          slot <= slot + 1'b1;
        end
        BS_R_DONE: begin
          count <= wptr;
          if (wptr == '0) begin
            dim_known <= 1'b0;
            dim       <= '0;
          end
          done   <= 1'b1;
          result <= make_res(STS_OK, 16'd0, 16'sd0, 9'(count - wptr), 1'b1);
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/cosine_top_k_vector_search_core.sv
// Top level of the cosine top-k vector search core: APB register file,
// front end, job queue and engine. Uses cvs_pkg, cvs_front, cvs_fifo, cvs_back.
//
// Items are taken when start is high and busy is low; results appear for one
// cycle each with done high and cannot be held off. Non-final components go
// straight into staging. A final add runs an id search, a sum of squares and a
// bit-serial square root, then one 17-step divide per component. A query runs
// the same normalization, then the dot products and the ranking sweeps over
// the score memory. Remove compacts the vector memory; clear empties the store.
// busy stays high until the item's last result is out. No clearing pass is
// needed after reset.
module cosine_top_k_vector_search_core import cvs_pkg::*; #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_DIM     = 64,
  parameter int MAX_MATCHES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LEN_W = $clog2(MAX_DIM + 1);

  logic [4:0]         match_limit;
  logic signed [15:0] min_score;
  logic               accept;
  logic               push;
  job_t               f_job;
  logic [LEN_W-1:0]   f_len;
  logic               q_empty;
  logic               q_full;
  logic [JOB_W+LEN_W-1:0] q_rdata;
  logic               pop;
  logic               back_busy;
  logic [DIM_W-1:0]   stg_raddr;
  logic signed [15:0] stg_rdata;

  // Register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      match_limit <= MATCH_LIMIT_RST;
      min_score   <= MIN_SCORE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MATCH_LIMIT: match_limit <= pwdata[4:0];
        REG_MIN_SCORE:   min_score   <= $signed(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MATCH_LIMIT: prdata = {27'd0, match_limit};
      default:         prdata = 32'(min_score);
    endcase
  end

  // Item handshake
  assign busy   = back_busy || !q_empty || q_full;
  assign accept = start && !busy;

  cvs_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .push      (push),
    .job       (f_job),
    .job_len   (f_len),
    .stg_raddr (stg_raddr),
    .stg_rdata (stg_rdata)
  );

  cvs_fifo #(.W(JOB_W + LEN_W)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_job, f_len}),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  cvs_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_DIM     (MAX_DIM),
    .MAX_MATCHES (MAX_MATCHES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .fifo_empty  (q_empty),
    .fifo_job    (job_t'(q_rdata[JOB_W+LEN_W-1:LEN_W])),
    .fifo_len    (q_rdata[LEN_W-1:0]),
    .pop         (pop),
    .stg_raddr   (stg_raddr),
    .stg_rdata   (stg_rdata),
    .match_limit (match_limit),
    .min_score   (min_score),
    .busy        (back_busy),
    .done        (done),
    .result      (result)
  );

endmodule

### dv/cvs_checker.sv
// Checker for the cosine top-k vector search core: mirrors the register port,
// predicts the results of every accepted item and compares them. Uses cvs_pkg.
`timescale 1ns / 1ps

module cvs_checker import cvs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  item_t       item,
  input  logic        done,
  input  result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          store_size
);

  localparam int ENTRIES = 256;
  localparam int DIM     = 64;
  localparam int MATCHES = 16;

  // Mirrored store and registers
  logic signed [15:0] vec_store [ENTRIES][DIM];
  logic [15:0]        key_store [ENTRIES];
  logic signed [15:0] staged    [DIM];
  logic signed [15:0] unit_buf  [DIM];
  int                 slot_score[ENTRIES];
  bit                 slot_used [ENTRIES];
  int                 n_stored;
  bit                 dim_known;
  int                 dim_len;
  int                 staged_len;
  logic [4:0]         limit_reg;
  logic signed [15:0] min_score_reg;

  result_t expected_results[$];

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic push_result(status_t st, logic [15:0] id, logic signed [15:0] score,
                             int cnt, logic last);
    result_t r;
    r.status      = st;
    r.match_id    = id;
    r.match_score = score;
    r.entry_count = cnt[8:0];
    r.result_last = last;
    expected_results = {expected_results, r};
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Unit-length version of the staged vector into unit_buf
  function automatic void normalize(int len);
    longint unsigned s, r, mag, q;
    int v;
    s = 0;
    for (int i = 0; i < len; i++) begin
      v = staged[i];
      s += longint'(v) * longint'(v);
    end
    if (s == 0) begin
      for (int i = 0; i < len; i++) unit_buf[i] = '0;
      return;
    end
    r = int_sqrt(s << 16);
    for (int i = 0; i < len; i++) begin
      v   = staged[i];
      mag = (v < 0) ? longint'(-v) : longint'(v);
      q   = ((mag << 23) + r / 2) / r;
      if (v < 0) unit_buf[i] = (q > 32768) ? -16'sd32768 : -q[15:0];
      else       unit_buf[i] = (q > 32767) ? 16'sd32767 : q[15:0];
    end
  endfunction

  function automatic int dot_score(int slot, int len);
    longint acc;
    longint unsigned mag, r;
    acc = 0;
    for (int i = 0; i < len; i++)
      acc += longint'(unit_buf[i]) * longint'(vec_store[slot][i]);
    mag = (acc < 0) ? -acc : acc;
    r   = (mag + 16384) >> 15;
    if (acc < 0) return (r > 32768) ? -32768 : -int'(r);
    return (r > 32767) ? 32767 : int'(r);
  endfunction

  // Work out the results of one accepted item
  task automatic predict(item_t it);
    int len, slot, lim, n, best, w;
    case (it.cmd)
      CMD_ADD, CMD_QUERY: begin
        if (staged_len < DIM) begin
          staged[staged_len] = it.element_value;
          staged_len++;
        end else begin
          staged_len = DIM + 1;
        end
        if (!it.element_last) return;
        len = staged_len;
        staged_len = 0;
        if (len > DIM || (dim_known && len != dim_len)) begin
          push_result(STS_DIM, '0, '0, n_stored, 1'b1);
        end else if (it.cmd == CMD_ADD) begin
          slot = n_stored;
          if (it.doc_id != 0)
            for (int i = 0; i < n_stored; i++)
              if (key_store[i] == it.doc_id) begin
                slot = i;
                break;
              end
          if (slot == n_stored && n_stored >= ENTRIES) begin
            push_result(STS_FULL, '0, '0, n_stored, 1'b1);
          end else begin
            normalize(len);
            for (int i = 0; i < len; i++) vec_store[slot][i] = unit_buf[i];
            key_store[slot] = it.doc_id;
            if (slot == n_stored) n_stored++;
            dim_known = 1'b1;
            dim_len   = len;
            push_result(STS_OK, '0, '0, n_stored, 1'b1);
          end
        end else begin
          lim = (limit_reg < MATCHES) ? limit_reg : MATCHES;
          n   = 0;
          normalize(len);
          for (int i = 0; i < n_stored; i++) begin
            slot_score[i] = dot_score(i, len);
            slot_used[i]  = slot_score[i] < int'(min_score_reg);
          end
          while (n < lim) begin
            best = -1;
            for (int i = 0; i < n_stored; i++)
              if (!slot_used[i] && (best < 0 || slot_score[i] > slot_score[best]))
                best = i;
            if (best < 0) break;
            slot_used[best] = 1'b1;
            n++;
            push_result(STS_OK, key_store[best], slot_score[best][15:0], n_stored, 1'b0);
          end
          if (n == 0) push_result(STS_NO_MATCH, '0, '0, n_stored, 1'b1);
          else expected_results[$].result_last = 1'b1;
        end
      end
      CMD_REMOVE: begin
        w = 0;
        for (int i = 0; i < n_stored; i++) begin
          if (key_store[i] == it.doc_id) continue;
          if (w != i) begin
            key_store[w] = key_store[i];
            vec_store[w] = vec_store[i];
          end
          w++;
        end
        push_result(STS_OK, '0, '0, n_stored - w, 1'b1);
        n_stored = w;
        if (n_stored == 0) begin
          dim_known = 1'b0;
          dim_len   = 0;
        end
      end
      default: begin
        n_stored   = 0;
        dim_known  = 1'b0;
        dim_len    = 0;
        staged_len = 0;
        push_result(STS_OK, '0, '0, 0, 1'b1);
      end
    endcase
  endtask

  task automatic compare(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report("result with nothing expected, status", got.status, -1);
      return;
    end
    want = expected_results.pop_front();
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.match_id != want.match_id) report("match_id", got.match_id, want.match_id);
    if (got.match_score != want.match_score)
      report("match_score", got.match_score, want.match_score);
    if (got.entry_count != want.entry_count)
      report("entry_count", got.entry_count, want.entry_count);
    if (got.result_last != want.result_last)
      report("result_last", got.result_last, want.result_last);
  endtask

  initial fail_count = 0;

  // Sample the channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      n_stored      = 0;
      dim_known     = 1'b0;
      dim_len       = 0;
      staged_len    = 0;
      limit_reg     = MATCH_LIMIT_RST;
      min_score_reg = MIN_SCORE_RST;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MATCH_LIMIT) limit_reg = pwdata[4:0];
        else min_score_reg = pwdata[15:0];
      end
      if (start && !busy) predict(item);
      if (done) compare(result);
    end
    pending    <= expected_results.size();
    store_size <= n_stored;
  end

endmodule

### dv/cosine_top_k_vector_search_core_tb.sv
// Testbench top for the cosine top-k vector search core: clock, reset, APB
// writes and item stimulus. Depends on cvs_pkg, the core and cvs_checker.
`timescale 1ns / 1ps

module cosine_top_k_vector_search_core_tb;
  import cvs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RAND_ITEMS  = 460;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, store_size;
  int cycles = 0;
  int burst_left = 0;
  int sent = 0;
  int cur_dim = 4;

  always #1 clk = ~clk;

  cosine_top_k_vector_search_core i_dut (
    .clk, .rst, .start, .busy, .item, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cvs_checker i_checker (
    .clk, .rst, .start, .busy, .item, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending, .store_size
  );

  // Run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cosine_top_k_vector_search_core_tb: FAIL");
      $finish;
    end
  end

  // One item; start stays high through a burst, gaps fall between bursts
  task automatic send_item(cmd_t cmd, logic signed [15:0] val, logic last,
                           logic [15:0] id);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    item.cmd           = cmd;
    item.element_value = val;
    item.element_last  = last;
    item.doc_id        = id;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  function automatic logic signed [15:0] pick_value(int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 4)) - 2);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'sh0;
    endcase
  endfunction

  // A vector of len components; the final one carries last_cmd
  task automatic send_vector(cmd_t cmd, cmd_t last_cmd, int len, logic [15:0] id,
                             int kind);
    for (int i = 0; i < len; i++)
      send_item((i == len - 1) ? last_cmd : cmd, pick_value(kind), i == len - 1, id);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (40) @(negedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] val);
    psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
  endfunction

  initial begin
    int limits[7] = '{16, 0, 1, 31, 4, 16, 20};
    int scores[7] = '{-32768, 0, 32767, -32768, -16384, 16384, 0};
    int r, per_phase;
    cmd_t c;

    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: empty store, extremes, zero vector, ids, lengths, removal, clear
    send_vector(CMD_QUERY, CMD_QUERY, 2, 16'h0, 0);
    send_item(CMD_ADD, 16'sh7fff, 1'b0, 16'd1);
    send_item(CMD_ADD, 16'sh8000, 1'b1, 16'd1);
    send_vector(CMD_ADD, CMD_ADD, 2, 16'd2, 3);
    send_vector(CMD_ADD, CMD_ADD, 2, 16'd0, 2);
    send_vector(CMD_ADD, CMD_ADD, 2, 16'd0, 1);
    send_vector(CMD_ADD, CMD_ADD, 2, 16'hffff, 0);
    send_vector(CMD_ADD, CMD_ADD, 2, 16'd1, 0);
    send_vector(CMD_QUERY, CMD_QUERY, 3, 16'h0, 0);
    send_vector(CMD_ADD, CMD_QUERY, 2, 16'h0, 2);
    send_vector(CMD_QUERY, CMD_ADD, 2, 16'd2, 0);
    send_item(CMD_REMOVE, 16'sh0, 1'b1, 16'd5);
    send_item(CMD_REMOVE, 16'sh0, 1'b0, 16'd0);
    send_vector(CMD_QUERY, CMD_QUERY, 2, 16'h0, 3);
    send_item(CMD_REMOVE, 16'sh0, 1'b1, 16'd1);
    send_item(CMD_REMOVE, 16'sh0, 1'b1, 16'd2);
    send_item(CMD_REMOVE, 16'sh0, 1'b1, 16'hffff);
    send_vector(CMD_ADD, CMD_ADD, 3, 16'd3, 0);
    send_item(CMD_ADD, 16'sh1234, 1'b0, 16'd4);
    send_item(CMD_CLEAR, 16'sh0, 1'b0, 16'h0);
    send_vector(CMD_QUERY, CMD_QUERY, 1, 16'h0, 0);
    wait_idle();

    // Random phases, one register setting each
    per_phase = RAND_ITEMS / 7;
    for (int p = 0; p < 7; p++) begin
      reg_write(REG_MATCH_LIMIT, 32'(limits[p]));
      reg_write(REG_MIN_SCORE, (p == 4) ? $urandom : 32'(scores[p]));
      sent = 0;
      while (sent < per_phase) begin
        if (store_size == 0 && $urandom_range(0, 1))
          cur_dim = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16)
                                                : $urandom_range(1, 6);
        r = $urandom_range(0, 99);
        if (store_size > 24 && r < 40) r = 75;
        if (r < 42)      send_vector(CMD_ADD, CMD_ADD, cur_dim, pick_id(),
                                     $urandom_range(0, 2));
        else if (r < 70) send_vector(CMD_QUERY, CMD_QUERY, cur_dim, pick_id(),
                                     $urandom_range(0, 2));
        else if (r < 80) send_item(CMD_REMOVE, 16'($urandom), 1'b1, pick_id());
        else if (r < 82) send_item(CMD_CLEAR, 16'($urandom), 1'($urandom),
                                   16'($urandom));
        else if (r < 88) begin
          c = $urandom_range(0, 1) ? CMD_ADD : CMD_QUERY;
          send_vector(c, c, cur_dim + $urandom_range(1, 2), pick_id(), 0);
        end else if (r < 94) begin
          c = $urandom_range(0, 1) ? CMD_ADD : CMD_QUERY;
          send_vector(c == CMD_ADD ? CMD_QUERY : CMD_ADD, c, cur_dim, pick_id(), 1);
        end else begin
          send_vector($urandom_range(0, 1) ? CMD_ADD : CMD_QUERY, CMD_ADD, cur_dim,
                      pick_id(), 3);
        end
      end
      wait_idle();
    end

    // Overlong vector, then a completely full store
    reg_write(REG_MATCH_LIMIT, 32'd16);
    reg_write(REG_MIN_SCORE, 32'hffff8000);
    send_item(CMD_CLEAR, 16'sh0, 1'b1, 16'h0);
    send_vector(CMD_ADD, CMD_ADD, 66, 16'd9, 0);
    send_vector(CMD_QUERY, CMD_QUERY, 65, 16'd9, 0);
    for (int i = 0; i < 256; i++)
      send_vector(CMD_ADD, CMD_ADD, 1, 16'h0, $urandom_range(0, 2));
    send_vector(CMD_ADD, CMD_ADD, 1, 16'h0, 0);
    send_vector(CMD_ADD, CMD_ADD, 1, 16'd77, 0);
    send_vector(CMD_QUERY, CMD_QUERY, 1, 16'h0, 0);
    send_item(CMD_REMOVE, 16'sh0, 1'b1, 16'h0);
    send_vector(CMD_QUERY, CMD_QUERY, 5, 16'h0, 0);
    wait_idle();

    if (pending != 0) $display("expected results never arrived: %0d", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("cosine_top_k_vector_search_core_tb: PASS");
    end else begin
      $display("cosine_top_k_vector_search_core_tb: FAIL");
    end
    $finish;
  end

endmodule
